// ===== sv/stbc_pkg.sv =====
package stbc_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned COUNT_W    = 31;
  localparam int unsigned UNIT_W     = 3;
  localparam int unsigned NUM_ENTRIES = 9;

  localparam logic [COUNT_W-1:0] MAX_COUNT  = {COUNT_W{1'b1}};
  localparam logic [CH_W-1:0]    SPACE_BYTE = 8'h20;
  localparam logic [CH_W-1:0]    ZERO_CHAR  = 8'h30;
  localparam logic [CH_W-1:0]    NINE_CHAR  = 8'h39;

  // Unit codes on the result channel
  localparam logic [UNIT_W-1:0] UNIT_NONE = 3'd0;
  localparam logic [UNIT_W-1:0] UNIT_KIBI = 3'd1;
  localparam logic [UNIT_W-1:0] UNIT_MEBI = 3'd2;
  localparam logic [UNIT_W-1:0] UNIT_GIBI = 3'd3;
  localparam logic [UNIT_W-1:0] UNIT_BAD  = 3'd4;

  // Suffix table: k kb kib m mb mib g gb gib
  function automatic logic [CH_W-1:0] sfx_char(input logic [3:0] idx, input logic [1:0] pos);
    logic [CH_W-1:0] lead;
    logic [CH_W-1:0] c;
    begin
      unique case (idx)
        4'd0, 4'd1, 4'd2: lead = 8'h6B;  // k
        4'd3, 4'd4, 4'd5: lead = 8'h6D;  // m
        default:          lead = 8'h67;  // g
      endcase
      case (pos)
        2'd0: c = lead;
        2'd1: c = (idx == 4'd1 || idx == 4'd4 || idx == 4'd7) ? 8'h62 : 8'h69;  // b or i
        2'd2: c = 8'h62;
        default: c = 8'h00;
      endcase
      sfx_char = c;
    end
  endfunction

  function automatic logic [1:0] sfx_len(input logic [3:0] idx);
    begin
      case (idx)
        4'd0, 4'd3, 4'd6: sfx_len = 2'd1;
        4'd1, 4'd4, 4'd7: sfx_len = 2'd2;
        default:          sfx_len = 2'd3;
      endcase
    end
  endfunction

endpackage

// ===== sv/size_text_to_byte_count.sv =====
// Size text to byte count. Feed the characters of a size string one beat at a
// time on in_ch; a zero byte ends the string and produces exactly one result
// beat, every other byte produces none. The string is read as optional leading
// blanks (any byte at or below space), decimal digits, optional blanks, and a
// unit suffix matched case-insensitively against k, kb, kib, m, mb, mib, g,
// gb, gib (first table match wins). The count is the number shifted by 0, 10,
// 20 or 30 bits; both the digit sum and the product saturate at 2^31-1 and set
// out_overflowed. An unknown suffix gives count 0 and unit code 4. Rate: one
// character per clock, sustained while no result is held back by out_stall.
// Each beat passes through the input register, and the terminating zero byte
// then through the result register, from which its result is offered. The
// input register only holds back a zero byte, and stalls the input, while the
// waiting result is itself stalled.
module size_text_to_byte_count
  import stbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CH_W-1:0]    in_ch,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [COUNT_W-1:0] out_byte_count,
  output logic [UNIT_W-1:0]  out_unit_code,
  output logic               out_overflowed
);

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_DIGIT = 2'd1,
    PH_MID   = 2'd2,
    PH_SFX   = 2'd3
  } phase_t;

  localparam int unsigned PROD_W = COUNT_W + 4;

  // Input register
  logic               st_valid_r;
  logic [CH_W-1:0]    st_ch_r;

  // Parse state
  phase_t             phase_r, phase_nxt;
  logic [COUNT_W-1:0] number_acc_r, number_acc_nxt;
  logic               sat_flag_r, sat_flag_nxt;
  logic [1:0]         suffix_pos_r, suffix_pos_nxt;
  logic [NUM_ENTRIES-1:0] entry_alive_r, entry_alive_nxt;
  logic [NUM_ENTRIES-1:0] entry_hit_r, entry_hit_nxt;

  // Result register
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_byte_count_r, out_count_nxt;
  logic [UNIT_W-1:0]  out_unit_code_r, out_unit_nxt;
  logic               out_overflowed_r, out_ovf_nxt;

  logic               out_free;
  logic               is_end;
  logic               advance;
  logic               emit;
  logic               is_digit;
  logic               is_blank;
  logic [PROD_W-1:0]  acc_ext;
  logic [PROD_W-1:0]  acc_sum;
  logic [CH_W-1:0]    ch_low;
  logic [NUM_ENTRIES-1:0] sfx_alive;
  logic [NUM_ENTRIES-1:0] sfx_hit;
  logic [1:0]         sfx_pos;
  logic [NUM_ENTRIES-1:0] matched;
  logic [COUNT_W-1:0] limit;

  // Handshake: the result register frees up when empty or being taken;
  // a zero byte may leave the input register only into a free result slot.
  assign out_free = !out_valid_r || !out_stall;
  assign is_end   = (st_ch_r == '0);
  assign advance  = st_valid_r && (!is_end || out_free);
  assign emit     = advance && is_end;
  assign in_stall = st_valid_r && !advance;

  assign out_valid      = out_valid_r;
  assign out_byte_count = out_byte_count_r;
  assign out_unit_code  = out_unit_code_r;
  assign out_overflowed = out_overflowed_r;

  assign is_digit = (st_ch_r >= ZERO_CHAR) && (st_ch_r <= NINE_CHAR);
  assign is_blank = (st_ch_r <= SPACE_BYTE);
  assign ch_low   = st_ch_r | SPACE_BYTE;

  // Accumulate by ten: acc*8 + acc*2 + digit, checked against the cap.
  assign acc_ext = {{(PROD_W-COUNT_W){1'b0}}, number_acc_r};
  assign acc_sum = (acc_ext << 3) + (acc_ext << 1)
                 + {{(PROD_W-4){1'b0}}, st_ch_r[3:0]};

  // One suffix byte against every table entry in parallel.
  always_comb begin
    sfx_alive = entry_alive_r;
    sfx_hit   = entry_hit_r;
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      if (entry_alive_r[e]) begin
        if (suffix_pos_r < sfx_len(4'(e))) begin
          if (ch_low != (sfx_char(4'(e), suffix_pos_r) | SPACE_BYTE)) begin
            sfx_alive[e] = 1'b0;
          end
        end else begin
          sfx_alive[e] = 1'b0;
          if (is_blank) begin
            sfx_hit[e] = 1'b1;
          end
        end
      end
    end
    sfx_pos = (suffix_pos_r == 2'd3) ? suffix_pos_r : suffix_pos_r + 2'd1;
  end

  // Result for a zero byte: pick the unit group, then shift with saturation.
  assign matched = entry_hit_r | entry_alive_r;

  always_comb begin
    out_unit_nxt = UNIT_NONE;
    if (phase_r == PH_SFX) begin
      if (|matched[2:0]) begin
        out_unit_nxt = UNIT_KIBI;
      end else if (|matched[5:3]) begin
        out_unit_nxt = UNIT_MEBI;
      end else if (|matched[8:6]) begin
        out_unit_nxt = UNIT_GIBI;
      end else begin
        out_unit_nxt = UNIT_BAD;
      end
    end

    unique case (out_unit_nxt)
      UNIT_KIBI: limit = MAX_COUNT >> 10;
      UNIT_MEBI: limit = MAX_COUNT >> 20;
      UNIT_GIBI: limit = MAX_COUNT >> 30;
      default:   limit = MAX_COUNT;
    endcase

    out_ovf_nxt = sat_flag_r;
    if (out_unit_nxt == UNIT_BAD) begin
      out_count_nxt = '0;
    end else if (number_acc_r > limit) begin
      out_count_nxt = MAX_COUNT;
      out_ovf_nxt   = 1'b1;
    end else begin
      unique case (out_unit_nxt)
        UNIT_KIBI: out_count_nxt = number_acc_r << 10;
        UNIT_MEBI: out_count_nxt = number_acc_r << 20;
        UNIT_GIBI: out_count_nxt = number_acc_r << 30;
        default:   out_count_nxt = number_acc_r;
      endcase
    end
  end

  // Parse state update for a non-zero byte; a zero byte returns to reset.
  always_comb begin
    phase_nxt       = phase_r;
    number_acc_nxt  = number_acc_r;
    sat_flag_nxt    = sat_flag_r;
    suffix_pos_nxt  = suffix_pos_r;
    entry_alive_nxt = entry_alive_r;
    entry_hit_nxt   = entry_hit_r;
    if (advance) begin
      if (is_end) begin
        phase_nxt       = PH_LEAD;
        number_acc_nxt  = '0;
        sat_flag_nxt    = 1'b0;
        suffix_pos_nxt  = '0;
        entry_alive_nxt = '1;
        entry_hit_nxt   = '0;
      end else begin
        unique case (phase_r)
          PH_LEAD, PH_DIGIT: begin
            if (is_digit) begin
              phase_nxt = PH_DIGIT;
              if (acc_sum > {{(PROD_W-COUNT_W){1'b0}}, MAX_COUNT}) begin
                number_acc_nxt = MAX_COUNT;
                sat_flag_nxt   = 1'b1;
              end else begin
                number_acc_nxt = acc_sum[COUNT_W-1:0];
              end
            end else if (is_blank) begin
              if (phase_r == PH_DIGIT) begin
                phase_nxt = PH_MID;
              end
            end else begin
              phase_nxt       = PH_SFX;
              suffix_pos_nxt  = sfx_pos;
              entry_alive_nxt = sfx_alive;
              entry_hit_nxt   = sfx_hit;
            end
          end
          PH_MID: begin
            if (!is_blank) begin
              phase_nxt       = PH_SFX;
              suffix_pos_nxt  = sfx_pos;
              entry_alive_nxt = sfx_alive;
              entry_hit_nxt   = sfx_hit;
            end
          end
          PH_SFX: begin
            suffix_pos_nxt  = sfx_pos;
            entry_alive_nxt = sfx_alive;
            entry_hit_nxt   = sfx_hit;
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      phase_r       <= PH_LEAD;
      number_acc_r  <= '0;
      sat_flag_r    <= 1'b0;
      suffix_pos_r  <= '0;
      entry_alive_r <= '1;
      entry_hit_r   <= '0;
    end else begin
      // Take a new beat whenever the input register empties or advances.
      if (!in_stall) begin
        st_valid_r <= in_valid;
        st_ch_r    <= in_ch;
      end
      phase_r       <= phase_nxt;
      number_acc_r  <= number_acc_nxt;
      sat_flag_r    <= sat_flag_nxt;
      suffix_pos_r  <= suffix_pos_nxt;
      entry_alive_r <= entry_alive_nxt;
      entry_hit_r   <= entry_hit_nxt;
      // Drop a taken result, load a new one.
      if (emit) begin
        out_valid_r      <= 1'b1;
        out_byte_count_r <= out_count_nxt;
        out_unit_code_r  <= out_unit_nxt;
        out_overflowed_r <= out_ovf_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // A string end leaves the parser at its reset point.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (phase_r == PH_LEAD) && (number_acc_r == '0) && !sat_flag_r)
    else $error("parser state not cleared after string end");

  // The digit sum only saturates at the cap.
  a_sat_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
    sat_flag_r |-> (number_acc_r == MAX_COUNT))
    else $error("saturation flag set below cap");

  // Suffix hits only exist once the suffix phase has started.
  a_hit_in_sfx: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_SFX) |-> (entry_hit_r == '0))
    else $error("suffix hit outside suffix phase");

  // An unknown suffix always reports a zero count.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_unit_code_r == UNIT_BAD)) |-> (out_byte_count_r == '0))
    else $error("unknown suffix with nonzero count");

endmodule
